FILE: rtl/core/lss_pkg.sv
// shared types and constants of the lifo stack with search
package lss_pkg;

   localparam int DEPTH = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_PEEK     = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/core/lss_ram.sv
// single write port, single registered read port ram
module lss_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lifo_stack_with_search.sv
// lifo stack: push goes from accept to the finish state, pop/peek pass through a ram read state, contains a scan
// the stack words sit in a one-port-read ram; contains walks it one entry per cycle
// a new request is taken while the previous result waits in the output register
// a new request is taken only in idle, after the last one has left finish; a full output register stalls finish
// synchronous active-high reset empties the stack and drops any pending result;
// ram contents are not cleared, only entries below the fill count are ever read
module lifo_stack_with_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic signed [lss_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic signed [lss_pkg::DATA_W-1:0]    rsp_value_out,
   output logic                                 rsp_found,
   output logic [lss_pkg::COUNT_OUT_W-1:0]      rsp_count,
   output logic                                 rsp_is_empty_flag
);

   lss_pkg::state_type state_ff, state_in;
   logic [lss_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [lss_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [lss_pkg::CNT_W-1:0]  top_idx;
   lss_pkg::op_type            op_ff, op_in;
   logic [lss_pkg::DATA_W-1:0] value_ff, value_in;
   lss_pkg::status_type        res_status_ff, res_status_in;
   logic [lss_pkg::DATA_W-1:0] res_value_ff, res_value_in;
   logic                       res_found_ff, res_found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_load;
   logic [1:0]                 rsp_status_ff;
   logic [lss_pkg::DATA_W-1:0] rsp_value_ff;
   logic                       rsp_found_ff;
   logic [lss_pkg::COUNT_OUT_W-1:0] rsp_count_ff;
   logic                       rsp_empty_ff;

   logic                        wr_en, rd_en;
   logic [lss_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   logic [lss_pkg::DATA_W-1:0]  wr_data, rd_data;

   lss_ram #(
      .DATA_W (lss_pkg::DATA_W),
      .ADDR_W (lss_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign top_idx = count_ff - lss_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lss_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= lss_pkg::COUNT_OUT_W'(count_ff);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_load      = 1'b0;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[lss_pkg::ADDR_W-1:0];
      wr_data       = req_value;
      rd_en         = 1'b0;
      rd_addr       = top_idx[lss_pkg::ADDR_W-1:0];

      unique case (state_ff)
         lss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = lss_pkg::op_type'(req_opcode);
               value_in      = req_value;
               res_status_in = lss_pkg::STAT_OK;
               res_value_in  = '0;
               res_found_in  = 1'b0;
               state_in      = lss_pkg::ST_FINISH;
               unique case (lss_pkg::op_type'(req_opcode))
                  lss_pkg::OP_PUSH: begin
                     if (count_ff == lss_pkg::CNT_W'(lss_pkg::DEPTH)) begin
                        res_status_in = lss_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + lss_pkg::CNT_W'(1);
                     end
                  end
                  lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_status_in = lss_pkg::STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = lss_pkg::ST_READ;
                     end
                  end
                  lss_pkg::OP_CONTAINS: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = lss_pkg::CNT_W'(1);
                        state_in = lss_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lss_pkg::ST_READ: begin
            res_value_in = rd_data;
            if (op_ff == lss_pkg::OP_POP) begin
               count_in = top_idx;
            end
            state_in = lss_pkg::ST_FINISH;
         end
         lss_pkg::ST_SCAN: begin
            // rd_data holds entry idx_ff - 1
            if (rd_data == value_ff) begin
               res_found_in = 1'b1;
               state_in     = lss_pkg::ST_FINISH;
            end else if (idx_ff == count_ff) begin
               state_in = lss_pkg::ST_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[lss_pkg::ADDR_W-1:0];
               idx_in  = idx_ff + lss_pkg::CNT_W'(1);
            end
         end
         lss_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lss_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty_flag = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lss_pkg::CNT_W'(lss_pkg::DEPTH))
      else $error("fill count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff))
         || (count_ff == $past(count_ff) + lss_pkg::CNT_W'(1))
         || (count_ff == $past(count_ff) - lss_pkg::CNT_W'(1)))
      else $error("fill count moved by more than one");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lss_pkg::STAT_EMPTY)
         |-> (rsp_value_out == '0) && rsp_is_empty_flag && !rsp_found)
      else $error("empty status beat carries data");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lss_pkg::ST_SCAN) |-> (idx_ff != '0) && (idx_ff <= count_ff))
      else $error("search index outside stored words");

endmodule

FILE: tb/lifo_stack_with_search_test.sv
// self-checking testbench for the lifo stack with search
module lifo_stack_with_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      lss_pkg::status_type        status;
      logic [lss_pkg::DATA_W-1:0] value_out;
      logic                       found;
      logic [6:0]                 count;
      logic                       no_words;
   } stack_result_t;

   typedef struct packed {
      lss_pkg::op_type            op;
      logic [lss_pkg::DATA_W-1:0] word;
   } stack_request_t;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_opcode = lss_pkg::OP_PUSH;
   logic signed [31:0] req_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic signed [31:0] rsp_value_out;
   logic              rsp_found;
   logic [6:0]        rsp_count;
   logic              rsp_is_empty_flag;

   // request beats waiting to be offered, and results still owed by the block
   stack_request_t    pending_reqs[$];
   stack_result_t     owed_results[$];

   // shadow stack that predicts every result
   logic [lss_pkg::DATA_W-1:0] shadow_words[lss_pkg::DEPTH];
   int                shadow_level = 0;

   int                mismatches = 0;
   int                req_sent = 0;
   int                rsp_beats = 0;
   logic              req_beat_done = 1'b0;
   int                hold_left = 0;
   int                next_hold_at = 100;

   // stimulus bookkeeping
   int                planned_level = 0;
   logic [lss_pkg::DATA_W-1:0] word_pool[16];

   lifo_stack_with_search u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_value_out     (rsp_value_out),
      .rsp_found         (rsp_found),
      .rsp_count         (rsp_count),
      .rsp_is_empty_flag (rsp_is_empty_flag)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic stack_result_t apply_request(lss_pkg::op_type op,
                                                   logic [lss_pkg::DATA_W-1:0] word);
      stack_result_t r;
      r = '0;
      r.status = lss_pkg::STAT_OK;
      case (op)
         lss_pkg::OP_PUSH: begin
            if (shadow_level >= lss_pkg::DEPTH) begin
               r.status = lss_pkg::STAT_FULL;
            end else begin
               shadow_words[shadow_level] = word;
               shadow_level++;
            end
         end
         lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
            if (shadow_level == 0) begin
               r.status = lss_pkg::STAT_EMPTY;
            end else begin
               r.value_out = shadow_words[shadow_level - 1];
               if (op == lss_pkg::OP_POP) shadow_level--;
            end
         end
         default: begin
            for (int i = 0; i < shadow_level; i++)
               if (shadow_words[i] == word) r.found = 1'b1;
         end
      endcase
      r.count = 7'(shadow_level);
      r.no_words = (shadow_level == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s got 0x%08h want 0x%08h (result beat %0d)",
               $realtime, what, got, want, rsp_beats);
      mismatches++;
   endtask

   task automatic add_req(lss_pkg::op_type op, logic [lss_pkg::DATA_W-1:0] word);
      stack_request_t r;
      r.op = op;
      r.word = word;
      pending_reqs.push_back(r);
      if (op == lss_pkg::OP_PUSH && planned_level < lss_pkg::DEPTH) planned_level++;
      if (op == lss_pkg::OP_POP && planned_level > 0) planned_level--;
   endtask

   // half the words come from a small pool so that contains hits often
   function automatic logic [lss_pkg::DATA_W-1:0] pick_word();
      if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   // sender: one payload change per falling edge at most
   always @(negedge clock) begin : sender
      stack_request_t next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat_done) begin
         // beat still waiting, hold it
      end else if (pending_reqs.size() != 0 &&
                   !((req_sent < 150 || req_sent >= 300) && $urandom_range(0, 99) < 11)) begin
         next_req = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_opcode <= next_req.op;
         req_value <= next_req.word;
         req_sent++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random gaps, a quiet stretch, and long hold-offs that back up the input
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (rsp_beats >= next_hold_at) begin
         rsp_ready <= 1'b0;
         hold_left <= 60;
         next_hold_at <= next_hold_at + 250;
      end else begin
         rsp_ready <= !((rsp_beats < 180 || rsp_beats >= 300) && $urandom_range(0, 99) < 11);
      end
   end

   always @(posedge clock) begin : monitor
      stack_result_t want;
      req_beat_done <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_value_out, '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_value_out !== want.value_out)
                  report_mismatch("value_out", rsp_value_out, want.value_out);
               if (rsp_found !== want.found)
                  report_mismatch("found", 32'(rsp_found), 32'(want.found));
               if (rsp_count !== want.count)
                  report_mismatch("count", 32'(rsp_count), 32'(want.count));
               if (rsp_is_empty_flag !== want.no_words)
                  report_mismatch("is_empty_flag", 32'(rsp_is_empty_flag),
                                  32'(want.no_words));
            end
            rsp_beats++;
         end
         if (req_valid && req_ready)
            owed_results.push_back(apply_request(lss_pkg::op_type'(req_opcode), req_value));
      end
   end

   initial begin : run_control
      int mode;
      word_pool[0] = 32'h8000_0000;
      word_pool[1] = 32'h7fff_ffff;
      word_pool[2] = 32'h0000_0000;
      word_pool[3] = 32'hffff_ffff;
      word_pool[4] = 32'h0000_0001;
      for (int i = 5; i < 16; i++) word_pool[i] = $urandom;

      // directed: empty corners, extreme words, hits at bottom and top, a miss
      add_req(lss_pkg::OP_POP, $urandom);
      add_req(lss_pkg::OP_PEEK, $urandom);
      add_req(lss_pkg::OP_CONTAINS, 32'h0000_0000);
      add_req(lss_pkg::OP_PUSH, 32'h8000_0000);
      add_req(lss_pkg::OP_PUSH, 32'h7fff_ffff);
      add_req(lss_pkg::OP_PUSH, 32'h0000_0000);
      add_req(lss_pkg::OP_PUSH, 32'hffff_ffff);
      add_req(lss_pkg::OP_PEEK, 32'h1234_5678);
      add_req(lss_pkg::OP_CONTAINS, 32'h8000_0000);
      add_req(lss_pkg::OP_CONTAINS, 32'hffff_ffff);
      add_req(lss_pkg::OP_CONTAINS, 32'h7fff_fffe);
      add_req(lss_pkg::OP_POP, 32'hffff_ffff);
      add_req(lss_pkg::OP_CONTAINS, 32'hffff_ffff);
      add_req(lss_pkg::OP_POP, 32'h0000_0000);
      add_req(lss_pkg::OP_POP, 32'h5555_5555);
      add_req(lss_pkg::OP_PEEK, 32'haaaa_aaaa);
      add_req(lss_pkg::OP_POP, 32'h0000_0000);
      add_req(lss_pkg::OP_POP, 32'h0000_0000);
      add_req(lss_pkg::OP_PEEK, 32'hffff_ffff);
      add_req(lss_pkg::OP_CONTAINS, 32'h8000_0000);

      // random: fill-to-full bursts, drain-to-empty runs and mixed traffic
      while (pending_reqs.size() < 480) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            while (planned_level < lss_pkg::DEPTH) add_req(lss_pkg::OP_PUSH, pick_word());
            repeat ($urandom_range(1, 3)) add_req(lss_pkg::OP_PUSH, pick_word());
            add_req(lss_pkg::OP_CONTAINS, pick_word());
            add_req(lss_pkg::OP_PEEK, $urandom);
         end else if (mode == 2) begin
            while (planned_level > 0) add_req(lss_pkg::OP_POP, $urandom);
            repeat ($urandom_range(1, 3))
               add_req(lss_pkg::op_type'($urandom_range(1, 3)), pick_word());
         end else begin
            // pushes slightly favored so the stack does not sit at empty
            repeat ($urandom_range(10, 30)) begin
               mode = $urandom_range(0, 4);
               add_req(mode == 4 ? lss_pkg::OP_PUSH : lss_pkg::op_type'(mode), pick_word());
            end
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("lifo_stack_with_search: match");
      else
         $display("lifo_stack_with_search: mismatch");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("lifo_stack_with_search: mismatch");
      $finish;
   end

endmodule
